FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication built on the clocked form
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

FILE: hw/rtl/adt_pkg.sv
// ---------------------------------------------------------------------------
// adt_pkg
// Types and codes of the advertisement dedupe table
// ---------------------------------------------------------------------------
package adt_pkg;

   // request command codes; the unused code behaves as a read
   localparam logic [1:0] CMD_REPORT = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // capacity register after reset
   localparam logic [6:0] CAP_RESET = 7'd64;

   // duplicate counter saturation value
   localparam logic [15:0] DUP_MAX = 16'hFFFF;

   // response status codes
   typedef enum logic [2:0] {
      STAT_NEW      = 3'd0,
      STAT_DUP      = 3'd1,
      STAT_DROP     = 3'd2,
      STAT_RD_OK    = 3'd3,
      STAT_RD_EMPTY = 3'd4,
      STAT_CLEARED  = 3'd5
   } status_type;

   // one table entry
   typedef struct packed {
      logic [47:0] address;
      logic [1:0]  kind;
      logic [7:0]  level;
   } entry_type;

   // sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_READ,
      SEQ_DONE
   } seq_state_type;

endpackage

FILE: hw/rtl/adt_table.sv
// ---------------------------------------------------------------------------
// adt_table
// Entry storage: one write port, one read port with registered data
// ---------------------------------------------------------------------------
module adt_table import adt_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_entry,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_entry
);

   entry_type entries_ff [DEPTH];
   entry_type rd_entry_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_entry;
      end
   end

   // read port, data in the cycle after the address
   always_ff @(posedge clock) begin
      rd_entry_ff <= entries_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

FILE: hw/rtl/adt_cmp.sv
// ---------------------------------------------------------------------------
// adt_cmp
// Shared key compare: address and address type of a stored entry
// ---------------------------------------------------------------------------
module adt_cmp import adt_pkg::*; (
   input  entry_type stored,
   input  entry_type key,
   output logic      match
);

   // level takes no part in the match
   assign match = (stored.address == key.address) && (stored.kind == key.kind);

endmodule

FILE: hw/rtl/advert_dedupe_table.sv
// ---------------------------------------------------------------------------
// advert_dedupe_table
// Deduplicating table of advertisers seen during one scan
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  command, address, kind, level, read slot
//   rsp      out        rsp_valid / rsp_stall  status, slot, entry, count, duplicates
//   csr      in         csr_write_enable       capacity
//
// A report walks the held entries through the one compare unit, one entry per
// cycle out of the table read port, until the first match. A read passes
// through the read state, a clear goes straight to done; both wait on a stall.
// One request at a time; req_stall is high from accept until the response is
// loaded into the output register. Synchronous reset empties the table by
// zeroing the fill count; no clearing pass over the storage is needed.
// ---------------------------------------------------------------------------
module advert_dedupe_table import adt_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [47:0]        req_device_address,
   input  logic [1:0]         req_address_kind,
   input  logic signed [7:0]  req_signal_level,
   input  logic [5:0]         req_read_slot,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_slot,
   output logic [47:0]        rsp_entry_address,
   output logic [1:0]         rsp_entry_kind,
   output logic signed [7:0]  rsp_entry_level,
   output logic [6:0]         rsp_device_count,
   output logic [15:0]        rsp_duplicate_total,
   // capacity register
   input  logic               csr_write_enable,
   input  logic [6:0]         csr_write_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = (KW > 7) ? KW : 7;

   seq_state_type state_ff, state_in;
   logic [6:0]    cap_ff, cap_in;
   entry_type     key_ff, key_in;
   logic [5:0]    rslot_ff, rslot_in;
   logic [KW-1:0] issue_ff, issue_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [KW-1:0] filled_ff, filled_in;
   logic [15:0]   dup_ff, dup_in;
   status_type    res_status_ff, res_status_in;
   logic [5:0]    res_slot_ff, res_slot_in;
   entry_type     res_entry_ff, res_entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [5:0]    rsp_slot_ff, rsp_slot_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [6:0]    rsp_count_ff, rsp_count_in;
   logic [15:0]   rsp_dup_ff, rsp_dup_in;

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [IW-1:0] mem_raddr;
   entry_type     rd_entry;
   logic          match;

   logic          req_accept;
   logic          out_free;
   logic          hit;
   logic          more;
   logic          scan_end;
   logic          room;
   logic [LW-1:0] eff_cap;

   // storage and the shared compare unit
   adt_table #(.DEPTH(TABLE_DEPTH), .AW(IW)) u_table (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (mem_waddr),
      .wr_entry (mem_wdata),
      .rd_addr  (mem_raddr),
      .rd_entry (rd_entry)
   );

   adt_cmp u_cmp (
      .stored (rd_entry),
      .key    (key_ff),
      .match  (match)
   );

   // handshake and scan decisions
   assign req_stall  = (state_ff != SEQ_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign hit        = (state_ff == SEQ_SCAN) && cmp_vld_ff && match;
   assign more       = (issue_ff < filled_ff);
   assign scan_end   = (state_ff == SEQ_SCAN) && !cmp_vld_ff && !more;
   assign eff_cap    = (LW'(cap_ff) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(cap_ff);
   assign room       = (LW'(filled_ff) < eff_cap);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               case (req_command)
                  CMD_REPORT: state_in = SEQ_SCAN;
                  CMD_CLEAR:  state_in = SEQ_DONE;
                  default:    state_in = SEQ_READ;
               endcase
            end
         end
         SEQ_SCAN: begin
            if (hit || scan_end) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_READ: state_in = SEQ_DONE;
         SEQ_DONE: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // datapath, table port and result
   always_comb begin
      cap_in        = csr_write_enable ? csr_write_data : cap_ff;
      key_in        = key_ff;
      rslot_in      = rslot_ff;
      issue_in      = issue_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      filled_in     = filled_ff;
      dup_in        = dup_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_entry_in  = res_entry_ff;
      mem_we        = 1'b0;
      mem_waddr     = cmp_idx_ff;
      mem_wdata     = key_ff;
      mem_raddr     = IW'(req_read_slot);
      case (state_ff)
         SEQ_IDLE: begin
            // latch the request; a read fetches its slot right away
            if (req_accept) begin
               key_in.address = req_device_address;
               key_in.kind    = req_address_kind;
               key_in.level   = req_signal_level;
               rslot_in       = req_read_slot;
               issue_in       = '0;
               cmp_vld_in     = 1'b0;
               if (req_command == CMD_CLEAR) begin
                  filled_in     = '0;
                  dup_in        = '0;
                  res_status_in = STAT_CLEARED;
                  res_slot_in   = '0;
                  res_entry_in  = '0;
               end
            end
         end
         SEQ_SCAN: begin
            mem_raddr = issue_ff[IW-1:0];
            if (hit) begin
               // lowest matching entry takes the new level
               mem_we        = 1'b1;
               mem_waddr     = cmp_idx_ff;
               if (dup_ff != DUP_MAX) begin
                  dup_in = dup_ff + 16'd1;
               end
               res_status_in = STAT_DUP;
               res_slot_in   = 6'(cmp_idx_ff);
               res_entry_in  = '0;
            end else if (scan_end) begin
               // no match: append while below capacity
               res_entry_in = '0;
               if (room) begin
                  mem_we        = 1'b1;
                  mem_waddr     = filled_ff[IW-1:0];
                  filled_in     = filled_ff + KW'(1);
                  res_status_in = STAT_NEW;
                  res_slot_in   = 6'(filled_ff);
               end else begin
                  res_status_in = STAT_DROP;
                  res_slot_in   = '0;
               end
            end else if (more) begin
               issue_in   = issue_ff + KW'(1);
               cmp_idx_in = issue_ff[IW-1:0];
               cmp_vld_in = 1'b1;
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         SEQ_READ: begin
            res_slot_in = rslot_ff;
            if (LW'(rslot_ff) < LW'(filled_ff)) begin
               res_status_in = STAT_RD_OK;
               res_entry_in  = rd_entry;
            end else begin
               res_status_in = STAT_RD_EMPTY;
               res_entry_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_dup_in    = rsp_dup_ff;
      if ((state_ff == SEQ_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_entry_in  = res_entry_ff;
         rsp_count_in  = 7'(filled_ff);
         rsp_dup_in    = dup_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cap_ff       <= CAP_RESET;
         filled_ff    <= '0;
         dup_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         filled_ff    <= filled_in;
         dup_ff       <= dup_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rslot_ff      <= rslot_in;
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_dup_ff    <= rsp_dup_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_entry_address   = rsp_entry_ff.address;
   assign rsp_entry_kind      = rsp_entry_ff.kind;
   assign rsp_entry_level     = rsp_entry_ff.level;
   assign rsp_device_count    = rsp_count_ff;
   assign rsp_duplicate_total = rsp_dup_ff;

endmodule

FILE: hw/rtl/adt_props.sv
// ---------------------------------------------------------------------------
// adt_props
// Port-level checks of the advertisement dedupe table, bound to the top
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adt_props import adt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic [5:0]         rsp_slot,
   input logic [47:0]        rsp_entry_address,
   input logic [1:0]         rsp_entry_kind,
   input logic signed [7:0]  rsp_entry_level,
   input logic [6:0]         rsp_device_count,
   input logic [15:0]        rsp_duplicate_total
);

   // a stalled response holds its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_entry_address) && $stable(rsp_device_count) && $stable(rsp_duplicate_total)), "stalled response changed")

   // one request at a time: the block is busy right after taking one
   `ASSERT_CLK(a_busy_after_req, clock, reset, (req_valid && !req_stall) |=> req_stall, "request taken while busy")

   // entry fields are zero unless a read hit a held entry
   `ASSERT_IMPLIES(a_entry_zero, clock, reset, rsp_valid && (rsp_status != STAT_RD_OK), (rsp_entry_address == 48'd0) && (rsp_entry_kind == 2'd0) && (rsp_entry_level == 8'sd0), "entry fields set on a non-read response")

   // a clear empties the table and the duplicate counter
   `ASSERT_IMPLIES(a_clear_zero, clock, reset, rsp_valid && (rsp_status == STAT_CLEARED), (rsp_device_count == 7'd0) && (rsp_duplicate_total == 16'd0) && (rsp_slot == 6'd0), "clear left state behind")

endmodule

bind advert_dedupe_table adt_props u_adt_props (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_slot            (rsp_slot),
   .rsp_entry_address   (rsp_entry_address),
   .rsp_entry_kind      (rsp_entry_kind),
   .rsp_entry_level     (rsp_entry_level),
   .rsp_device_count    (rsp_device_count),
   .rsp_duplicate_total (rsp_duplicate_total)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the advertisement dedupe table
//
// A queue-fed driver offers requests with random idle bursts; a clocked
// monitor stalls responses at random and checks each one against an in-bench
// model of the dedupe table. The run walks several capacity settings (zero,
// one, lowered below the held count, full depth and beyond), fills the table
// to its limit, holds the response side off for a long stretch and finally
// runs a stretch of repeated reports with no idling on either side.
// ----------------------------------------------------------------------------
module tb_top import adt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 64;
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 80;
   localparam int TAIL_REPORTS = 32;
   // the fourth command code acts as a read
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct {
      logic [1:0]        command;
      logic [47:0]       address;
      logic [1:0]        kind;
      logic signed [7:0] level;
      logic [5:0]        read_slot;
   } advert_request_type;

   typedef struct {
      status_type        status;
      logic [5:0]        slot;
      logic [47:0]       address;
      logic [1:0]        kind;
      logic signed [7:0] level;
      logic [6:0]        count;
      logic [15:0]       dups;
   } table_reply_type;

   typedef struct {
      logic [47:0] address;
      logic [1:0]  kind;
   } advertiser_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // block ports
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_command = CMD_REPORT;
   logic [47:0]       req_device_address = '0;
   logic [1:0]        req_address_kind = '0;
   logic signed [7:0] req_signal_level = '0;
   logic [5:0]        req_read_slot = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_status;
   logic [5:0]        rsp_slot;
   logic [47:0]       rsp_entry_address;
   logic [1:0]        rsp_entry_kind;
   logic signed [7:0] rsp_entry_level;
   logic [6:0]        rsp_device_count;
   logic [15:0]       rsp_duplicate_total;
   logic              csr_write_enable = 1'b0;
   logic [6:0]        csr_write_data = CAP_RESET;

   advert_dedupe_table #(.TABLE_DEPTH(SLOTS)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_device_address  (req_device_address),
      .req_address_kind    (req_address_kind),
      .req_signal_level    (req_signal_level),
      .req_read_slot       (req_read_slot),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_entry_address   (rsp_entry_address),
      .rsp_entry_kind      (rsp_entry_kind),
      .rsp_entry_level     (rsp_entry_level),
      .rsp_device_count    (rsp_device_count),
      .rsp_duplicate_total (rsp_duplicate_total),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   // shared bench state
   advert_request_type pending_requests[$];
   table_reply_type    expected_replies[$];
   advert_request_type offered_request;
   advertiser_type     scan_pool[$];
   logic            bursts_on = 1'b1;
   logic            hold_wanted = 1'b0;
   logic            long_hold_done = 1'b0;
   int              requests_taken = 0;
   int              error_count = 0;
   int              status_tally[8] = '{default: 0};

   // model of the table: held entries, counters and capacity
   logic [47:0]       held_address[SLOTS];
   logic [1:0]        held_kind[SLOTS];
   logic signed [7:0] held_level[SLOTS];
   int                held_count = 0;
   logic [15:0]       repeat_total = '0;
   logic [6:0]        capacity_now = CAP_RESET;

   // apply one request to the model and return the response it should give
   function automatic table_reply_type dedupe_lookup(advert_request_type rq);
      table_reply_type r;
      int hit;
      int limit;
      r.status = STAT_NEW;
      r.slot = '0;
      r.address = '0;
      r.kind = '0;
      r.level = '0;
      hit = -1;
      limit = (capacity_now > SLOTS) ? SLOTS : int'(capacity_now);
      if (rq.command == CMD_REPORT) begin
         for (int i = 0; i < held_count; i++) begin
            if (hit < 0 && held_kind[i] == rq.kind && held_address[i] == rq.address)
               hit = i;
         end
         if (hit >= 0) begin
            held_level[hit] = rq.level;
            if (repeat_total != DUP_MAX)
               repeat_total = repeat_total + 16'd1;
            r.status = STAT_DUP;
            r.slot = hit[5:0];
         end else if (held_count < limit) begin
            held_address[held_count] = rq.address;
            held_kind[held_count] = rq.kind;
            held_level[held_count] = rq.level;
            r.slot = held_count[5:0];
            held_count++;
         end else begin
            r.status = STAT_DROP;
         end
      end else if (rq.command == CMD_CLEAR) begin
         held_count = 0;
         repeat_total = '0;
         r.status = STAT_CLEARED;
      end else begin
         r.slot = rq.read_slot;
         if (rq.read_slot < held_count) begin
            r.status = STAT_RD_OK;
            r.address = held_address[rq.read_slot];
            r.kind = held_kind[rq.read_slot];
            r.level = held_level[rq.read_slot];
         end else begin
            r.status = STAT_RD_EMPTY;
         end
      end
      r.count = held_count[6:0];
      r.dups = repeat_total;
      return r;
   endfunction

   // request driver: takes the next pending request, idles in bursts
   always @(posedge clock) begin : drive_requests
      int send_gap;
      logic took;
      logic next_valid;
      if (reset) begin
         send_gap = 0;
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            expected_replies.push_back(dedupe_lookup(offered_request));
            requests_taken++;
         end
         next_valid = req_valid && !took;
         if (!next_valid) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (bursts_on && pending_requests.size() != 0
                         && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 11);
            end else if (pending_requests.size() != 0) begin
               offered_request = pending_requests.pop_front();
               next_valid = 1'b1;
               req_command <= offered_request.command;
               req_device_address <= offered_request.address;
               req_address_kind <= offered_request.kind;
               req_signal_level <= offered_request.level;
               req_read_slot <= offered_request.read_slot;
            end
         end
         req_valid <= next_valid;
      end
   end

   task automatic check_field(string name, logic signed [48:0] want,
                              logic signed [48:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endtask

   // response monitor: random stall bursts, one long hold-off, field checks
   always @(posedge clock) begin : check_replies
      int stall_left;
      logic stall_next;
      table_reply_type want;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("response with no request waiting, status %0d", rsp_status);
               error_count++;
            end else begin
               want = expected_replies.pop_front();
               status_tally[rsp_status]++;
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  error_count++;
               end
               check_field("slot", 49'(want.slot), 49'(rsp_slot));
               check_field("entry_address", 49'(want.address), 49'(rsp_entry_address));
               check_field("entry_kind", 49'(want.kind), 49'(rsp_entry_kind));
               check_field("entry_level", 49'(want.level), 49'(rsp_entry_level));
               check_field("device_count", 49'(want.count), 49'(rsp_device_count));
               check_field("duplicate_total", 49'(want.dups), 49'(rsp_duplicate_total));
            end
         end
         stall_next = 1'b0;
         if (stall_left != 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (hold_wanted && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            stall_next = 1'b1;
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            stall_next = 1'b1;
         end
         rsp_stall <= stall_next;
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin : watch_progress
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no request or response moved for %0d cycles", quiet_cycles);
            $display("advert_dedupe_table: mismatch");
            $finish;
         end
      end
   end

   task automatic queue_request(logic [1:0] command, logic [47:0] address,
                                logic [1:0] kind, logic signed [7:0] level,
                                logic [5:0] read_slot);
      advert_request_type rq;
      rq.command = command;
      rq.address = address;
      rq.kind = kind;
      rq.level = level;
      rq.read_slot = read_slot;
      pending_requests.push_back(rq);
   endtask

   // wait until the block is idle and every response has been checked
   task automatic settle();
      while (pending_requests.size() != 0 || req_valid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [6:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      capacity_now = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // one random request: mostly reports of known advertisers, some new ones,
   // near neighbors of known ones, reads and the odd clear
   task automatic queue_random(int new_pct, int clear_pct);
      advertiser_type who;
      int roll;
      int top;
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) begin
         scan_pool.delete();
         queue_request(CMD_CLEAR, {16'($urandom), 32'($urandom)}, 2'($urandom),
                       8'($urandom), 6'($urandom));
      end else if (roll < clear_pct + 14) begin
         top = (scan_pool.size() < 63) ? scan_pool.size() : 63;
         queue_request((roll < clear_pct + 2) ? CMD_SPARE : CMD_READ,
                       {16'($urandom), 32'($urandom)}, 2'($urandom), 8'($urandom),
                       $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, top)));
      end else begin
         if (scan_pool.size() == 0 || $urandom_range(0, 99) < new_pct) begin
            who.address = {16'($urandom), 32'($urandom)};
            who.kind = 2'($urandom);
            // neighbor of a known advertiser: one address bit or the kind differs
            if (scan_pool.size() != 0 && $urandom_range(0, 3) == 0) begin
               who = scan_pool[$urandom_range(0, scan_pool.size() - 1)];
               if ($urandom_range(0, 1))
                  who.address = who.address ^ (48'd1 << $urandom_range(0, 47));
               else
                  who.kind = who.kind + 2'($urandom_range(1, 3));
            end
            scan_pool.push_back(who);
         end else begin
            who = scan_pool[$urandom_range(0, scan_pool.size() - 1)];
         end
         queue_request(CMD_REPORT, who.address, who.kind, 8'($urandom), 6'($urandom));
      end
   endtask

   // test sequence
   initial begin : run_scenario
      int phase_cap[8]     = '{3, 64, 12, 0, 127, 1, 20, 64};
      int phase_items[8]   = '{50, 70, 50, 30, 100, 40, 60, 60};
      int phase_new[8]     = '{50, 60, 40, 50, 80, 50, 40, 40};
      int phase_clear[8]   = '{4, 0, 0, 3, 0, 4, 3, 2};
      bit phase_fresh[8]   = '{1, 0, 0, 1, 1, 1, 1, 0};
      bit phase_bursts[8]  = '{1, 1, 1, 1, 1, 0, 1, 1};
      logic [47:0] ones;
      logic [47:0] loud;
      ones = 48'hFFFF_FFFF_FFFF;
      loud = 48'hA5C3_0F96_1E78;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, field extremes, duplicates, kinds, clear
      queue_request(CMD_READ, '0, '0, '0, 6'd0);
      queue_request(CMD_REPORT, '0, 2'd0, -8'sd128, '0);
      queue_request(CMD_REPORT, ones, 2'd3, 8'sd127, 6'd63);
      queue_request(CMD_REPORT, '0, 2'd1, 8'sd0, '0);
      queue_request(CMD_REPORT, ones, 2'd2, -8'sd1, '0);
      queue_request(CMD_REPORT, ones, 2'd3, -8'sd1, '0);
      queue_request(CMD_REPORT, '0, 2'd0, 8'sd5, '0);
      queue_request(CMD_READ, ones, 2'd3, 8'sd127, 6'd0);
      queue_request(CMD_READ, '0, '0, '0, 6'd1);
      queue_request(CMD_READ, '0, '0, '0, 6'd3);
      queue_request(CMD_READ, '0, '0, '0, 6'd4);
      queue_request(CMD_READ, '0, '0, '0, 6'd63);
      queue_request(CMD_SPARE, '0, '0, '0, 6'd2);
      queue_request(CMD_REPORT, 48'h0000_0000_0001, 2'd0, 8'sd1, '0);
      queue_request(CMD_REPORT, 48'h8000_0000_0000, 2'd0, -8'sd128, '0);
      queue_request(CMD_REPORT, 48'h0000_0000_0001, 2'd0, 8'sd2, '0);
      queue_request(CMD_CLEAR, ones, 2'd3, -8'sd1, 6'd63);
      queue_request(CMD_READ, '0, '0, '0, 6'd0);
      queue_request(CMD_REPORT, ones, 2'd3, 8'sd127, '0);
      queue_request(CMD_READ, '0, '0, '0, 6'd0);
      settle();

      // random phases over several capacity settings
      for (int p = 0; p < 8; p++) begin
         write_capacity(7'(phase_cap[p]));
         bursts_on = phase_bursts[p];
         if (phase_fresh[p]) begin
            scan_pool.delete();
            queue_request(CMD_CLEAR, '0, '0, '0, '0);
         end
         for (int n = 0; n < phase_items[p]; n++)
            queue_random(phase_new[p], phase_clear[p]);
         // long response hold-off while the full-depth fill is under way
         if (p == 4)
            hold_wanted = 1'b1;
         settle();
      end

      // no idling from here on: repeated reports of one advertiser, reads between
      bursts_on = 1'b0;
      write_capacity(7'd1);
      queue_request(CMD_CLEAR, '0, '0, '0, '0);
      queue_request(CMD_REPORT, loud, 2'd1, -8'sd60, '0);
      for (int n = 0; n < TAIL_REPORTS; n++) begin
         queue_request(CMD_REPORT, loud, 2'd1, 8'(n), '0);
         if (n % 8 == 0) begin
            queue_request(CMD_READ, '0, '0, '0, 6'd0);
            queue_request(CMD_REPORT, ~loud, 2'd1, 8'sd3, '0);
         end
      end
      queue_request(CMD_READ, '0, '0, '0, 6'd0);
      queue_request(CMD_CLEAR, '0, '0, '0, '0);
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d requests checked over capacities 0, 1, lowered, 64 and 127,",
               requests_taken);
      $display("     new %0d dup %0d drop %0d read %0d empty %0d clear %0d",
               status_tally[STAT_NEW], status_tally[STAT_DUP], status_tally[STAT_DROP],
               status_tally[STAT_RD_OK], status_tally[STAT_RD_EMPTY],
               status_tally[STAT_CLEARED]);
      if (error_count == 0)
         $display("advert_dedupe_table: match");
      else
         $display("advert_dedupe_table: mismatch");
      $finish;
   end

endmodule
